@@ hdl/icorr_pkg.sv @@
// ----------------------------------------------------------------------------
// icorr_pkg
// Shared types and constants of the streaming 2D correlation block.
// ----------------------------------------------------------------------------
package icorr_pkg;

  // Configuration port
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KROW0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KROW1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KROW2  = 3'd4;

  localparam int WREG_W = 11;
  localparam int HREG_W = 13;
  localparam int POS_W  = 13;  // row position and all width/height compares

  localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd1024;
  localparam logic [HREG_W-1:0] HEIGHT_LIMIT = 13'd4096;

  // Kernel storage: three rows of three signed coefficients
  localparam int COEF_W    = 16;
  localparam int KROWS_MAX = 3;
  localparam int KCOLS_MAX = 3;

  // Result fields
  localparam int SUM_W  = 32;
  localparam int X_W    = 10;
  localparam int Y_W    = 12;
  localparam int STEP_W = 2;   // distance of a result column from the newest column

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [KROWS_MAX-1:0][KCOLS_MAX-1:0][COEF_W-1:0] coef_t;

  typedef struct packed {
    logic               command;
    logic signed [15:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] result_value;
    logic [X_W-1:0]          out_x;
    logic [Y_W-1:0]          out_y;
    logic                    last_of_run;
    logic                    end_of_frame;
  } out_item_t;

  // Per-item description of the results an item produces
  typedef struct packed {
    logic              has_res;   // item produces at least one result
    logic              last_col;  // item is at the last column of its row
    logic              ylast;     // results belong to the last image row
    logic [STEP_W-1:0] step0;     // distance of the first result from the newest column
    logic [X_W-1:0]    x_hi;      // column of the newest window column
    logic [Y_W-1:0]    y;         // output row
  } run_t;

endpackage

@@ hdl/icorr_ram.sv @@
// ----------------------------------------------------------------------------
// icorr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icorr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/icorr_lines.sv @@
// ----------------------------------------------------------------------------
// icorr_lines
// Raster position tracking, line memory read-modify-write and input stage.
// ----------------------------------------------------------------------------
module icorr_lines #(
  parameter int KR        = 3,
  parameter int KC        = 3,
  parameter int MAX_WIDTH = 1024,
  parameter int PB        = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [icorr_pkg::POS_W-1:0]    width_eff,
  input  logic [icorr_pkg::POS_W-1:0]    height_eff,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  icorr_pkg::in_item_t            pix_data,
  input  logic                           take,
  output logic                           a_valid,
  output icorr_pkg::run_t                a_run,
  output logic [KR-1:0][PB-1:0]          column
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int PW      = icorr_pkg::POS_W;
  localparam int SW      = icorr_pkg::STEP_W;
  localparam int LS_ROWS = (KR > 1) ? KR - 1 : 1;
  localparam int LS_W    = LS_ROWS * PB;

  logic [CW-1:0] col_pos;
  logic [PW-1:0] row_pos;

  logic [PW-1:0] col_ext, col_cl13, total, y_full;
  logic [CW-1:0] col_cl;
  logic          last_col, last_row, img_row, out_row, accept, a_go;
  logic [PB-1:0] sample;
  icorr_pkg::run_t run_in;

  logic [PB-1:0]                a_sample;
  logic [CW-1:0]                a_addr;
  logic                         a_fwd;
  logic [LS_ROWS-1:0][PB-1:0]   a_fwd_word, ram_q, old_word, new_word;

  // Position of the incoming item, clamped to the active bounds
  assign col_ext  = PW'(col_pos);
  assign col_cl13 = (col_ext >= width_eff) ? width_eff - PW'(1) : col_ext;
  assign col_cl   = col_cl13[CW-1:0];
  assign last_col = (col_cl13 == width_eff - PW'(1));
  assign total    = height_eff + PW'(KR - 1);
  assign last_row = ({1'b0, row_pos} + (PW + 1)'(1)) >= {1'b0, total};
  assign img_row  = row_pos < height_eff;
  assign y_full   = row_pos - PW'(KR - 1);
  assign out_row  = (row_pos >= PW'(KR - 1)) && (y_full < height_eff);

  assign sample = (pix_data.command == icorr_pkg::CMD_PIXEL && img_row) ?
                  pix_data.pixel_value[PB-1:0] : '0;

  always_comb begin
    run_in.has_res  = out_row && (last_col || col_cl13 >= PW'(KC - 1));
    run_in.last_col = last_col;
    run_in.ylast    = ({1'b0, row_pos} + (PW + 1)'(1)) == {1'b0, total};
    if (last_col && col_cl13 < PW'(KC - 1)) begin
      run_in.step0 = col_cl13[SW-1:0];
    end else begin
      run_in.step0 = SW'(KC - 1);
    end
    run_in.x_hi = col_cl13[icorr_pkg::X_W-1:0];
    run_in.y    = y_full[icorr_pkg::Y_W-1:0];
  end

  assign accept    = pix_valid && !pix_stall;
  assign a_go      = a_valid && take;
  assign pix_stall = a_valid && !take;

  // Forward the word written in the same cycle as a read of the same entry
  assign old_word = a_fwd ? a_fwd_word : ram_q;

  always_comb begin
    for (int m = 0; m < LS_ROWS; m++) begin
      if (m + 1 < LS_ROWS) begin
        new_word[m] = old_word[m + 1];
      end else begin
        new_word[m] = a_sample;
      end
    end
    for (int m = 0; m < KR; m++) begin
      if (m < KR - 1) begin
        column[m] = old_word[m];
      end else begin
        column[m] = a_sample;
      end
    end
  end

  icorr_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (a_go),
    .wr_addr (a_addr),
    .wr_data (new_word),
    .rd_en   (accept),
    .rd_addr (col_cl),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      a_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        if (last_col) begin
          col_pos <= '0;
          row_pos <= last_row ? '0 : row_pos + PW'(1);
        end else begin
          col_pos <= col_cl + CW'(1);
          row_pos <= (row_pos >= total) ? total - PW'(1) : row_pos;
        end
      end else if (a_go) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_run      <= run_in;
      a_sample   <= sample;
      a_addr     <= col_cl;
      a_fwd      <= a_go && (a_addr == col_cl);
      a_fwd_word <= new_word;
    end
  end

endmodule

@@ hdl/icorr_mac.sv @@
// ----------------------------------------------------------------------------
// icorr_mac
// Window register, result sequencer, product stage and sum/output register.
// ----------------------------------------------------------------------------
module icorr_mac #(
  parameter int KR = 3,
  parameter int KC = 3,
  parameter int PB = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  icorr_pkg::coef_t          coefs,
  input  logic                      a_valid,
  input  icorr_pkg::run_t           a_run,
  input  logic [KR-1:0][PB-1:0]     column,
  output logic                      take,
  output logic                      res_valid,
  input  logic                      res_stall,
  output icorr_pkg::out_item_t      res_data
);

  localparam int SW  = icorr_pkg::STEP_W;
  localparam int XW  = icorr_pkg::X_W;
  localparam int YW  = icorr_pkg::Y_W;
  localparam int SUW = icorr_pkg::SUM_W;
  localparam int PRW = PB + icorr_pkg::COEF_W;

  logic [KR-1:0][KC-1:0][PB-1:0] win, win_next;

  // Sequencer stage
  logic          b_valid, b_lastcol, b_ylast, b_last, b_issue;
  logic [SW-1:0] b_step;
  logic [XW-1:0] b_xhi;
  logic [YW-1:0] b_y;

  // Product stage
  logic                          c_valid, c_last, c_eof;
  logic [XW-1:0]                 c_x;
  logic [YW-1:0]                 c_y;
  logic [KR-1:0][KC-1:0][SUW-1:0] c_prod, prod_next;

  logic d_free, c_free, a_go;
  logic [SUW-1:0] sum;

  assign d_free  = !res_valid || !res_stall;
  assign c_free  = !c_valid || d_free;
  assign b_last  = (b_step == '0) || !b_lastcol;
  assign b_issue = b_valid && c_free;
  assign take    = !b_valid || (b_issue && b_last);
  assign a_go    = a_valid && take;

  always_comb begin
    for (int m = 0; m < KR; m++) begin
      for (int j = 0; j < KC - 1; j++) begin
        win_next[m][j] = win[m][j + 1];
      end
      win_next[m][KC-1] = column[m];
    end
  end

  // Result at distance b_step from the newest column uses coefficient n on
  // window column n + KC-1 - b_step; columns to its right count as zero.
  always_comb begin
    for (int m = 0; m < KR; m++) begin
      for (int n = 0; n < KC; n++) begin
        logic [SW-1:0]        jj;
        logic [PB-1:0]        pix;
        logic signed [PRW-1:0] p;
        jj  = SW'(n + KC - 1) - b_step;
        pix = (SW'(n) <= b_step) ? win[m][jj] : '0;
        p   = $signed(pix) * $signed(coefs[m][n]);
        prod_next[m][n] = SUW'(p);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int m = 0; m < KR; m++) begin
      for (int n = 0; n < KC; n++) begin
        sum = sum + c_prod[m][n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (a_go) begin
        win     <= win_next;
        b_valid <= a_run.has_res;
      end else if (b_issue && b_last) begin
        b_valid <= 1'b0;
      end
      if (c_free) begin
        c_valid <= b_valid;
      end
      if (d_free) begin
        res_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_step    <= a_run.step0;
      b_lastcol <= a_run.last_col;
      b_ylast   <= a_run.ylast;
      b_xhi     <= a_run.x_hi;
      b_y       <= a_run.y;
    end else if (b_issue) begin
      b_step <= b_step - SW'(1);
    end
    if (b_issue) begin
      c_prod <= prod_next;
      c_x    <= b_xhi - XW'(b_step);
      c_y    <= b_y;
      c_last <= b_last;
      c_eof  <= b_ylast && b_lastcol && (b_step == '0);
    end
    if (c_valid && d_free) begin
      res_data.result_value <= sum;
      res_data.out_x        <= c_x;
      res_data.out_y        <= c_y;
      res_data.last_of_run  <= c_last;
      res_data.end_of_frame <= c_eof;
    end
  end

endmodule

@@ hdl/image_correlation_2d.sv @@
// ----------------------------------------------------------------------------
// image_correlation_2d
// Streaming 2D correlation over a signed raster image with line memory.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  pix       in         pix_valid / pix_stall  icorr_pkg::in_item_t
//  res       out        res_valid / res_stall  icorr_pkg::out_item_t
//  cfg       in         cfg_write              cfg_index, cfg_data
//
// One input transaction per clock unless pix_stall holds it. An item at the
// last column of a row yields up to KERNEL_COLS results, one per clock while
// res_stall is low, so the input holds there; the result sequencer sets the rate.
// An accepted item passes the A, B and C registers before its first result reaches D.
// Synchronous reset clears positions, the window and all valid flags; the
// line memory is not cleared and needs no clearing pass.
// res_stall back-pressures all stages and reaches pix_stall in the same cycle.
//
// Pipeline:
//   A  - accept, read line memory at the clamped column
//   B  - read-modify-write of the line memory, window shift, result sequencer
//   C  - products of window and kernel
//   D  - sum, output register
// ----------------------------------------------------------------------------
module image_correlation_2d #(
  parameter int KERNEL_ROWS = 3,
  parameter int KERNEL_COLS = 3,
  parameter int MAX_WIDTH   = 1024,
  parameter int PIXEL_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  icorr_pkg::in_item_t               pix_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output icorr_pkg::out_item_t              res_data,
  input  logic                              cfg_write,
  input  logic [icorr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icorr_pkg::CFG_W-1:0]       cfg_data
);

  localparam int PW = icorr_pkg::POS_W;
  localparam logic [PW-1:0] MaxWidth = PW'(MAX_WIDTH);

  logic [icorr_pkg::WREG_W-1:0] width_reg;
  logic [icorr_pkg::HREG_W-1:0] height_reg;
  icorr_pkg::coef_t             kern;

  logic [PW-1:0] width_ext, width_eff, height_eff;

  logic                              a_valid, take;
  icorr_pkg::run_t                   a_run;
  logic [KERNEL_ROWS-1:0][PIXEL_BITS-1:0] column;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= icorr_pkg::WIDTH_RESET;
      height_reg <= icorr_pkg::HEIGHT_RESET;
      kern       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        icorr_pkg::REG_WIDTH:  width_reg  <= cfg_data[icorr_pkg::WREG_W-1:0];
        icorr_pkg::REG_HEIGHT: height_reg <= cfg_data[icorr_pkg::HREG_W-1:0];
        icorr_pkg::REG_KROW0:  kern[0]    <= cfg_data;
        icorr_pkg::REG_KROW1:  kern[1]    <= cfg_data;
        icorr_pkg::REG_KROW2:  kern[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one; oversize bounds saturate
  assign width_ext  = PW'(width_reg);
  assign width_eff  = (width_reg == '0)     ? PW'(1) :
                      (width_ext > MaxWidth) ? MaxWidth : width_ext;
  assign height_eff = (height_reg == '0)                  ? PW'(1) :
                      (height_reg > icorr_pkg::HEIGHT_LIMIT) ? icorr_pkg::HEIGHT_LIMIT :
                      height_reg;

  icorr_lines #(
    .KR        (KERNEL_ROWS),
    .KC        (KERNEL_COLS),
    .MAX_WIDTH (MAX_WIDTH),
    .PB        (PIXEL_BITS)
  ) u_lines (
    .clk        (clk),
    .rst        (rst),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_data   (pix_data),
    .take       (take),
    .a_valid    (a_valid),
    .a_run      (a_run),
    .column     (column)
  );

  icorr_mac #(
    .KR (KERNEL_ROWS),
    .KC (KERNEL_COLS),
    .PB (PIXEL_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .coefs     (kern),
    .a_valid   (a_valid),
    .a_run     (a_run),
    .column    (column),
    .take      (take),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

@@ hdl/icorr_check.sv @@
// ----------------------------------------------------------------------------
// icorr_check
// Port-level assertions for the 2D correlation block, bound to the top level.
// ----------------------------------------------------------------------------
module icorr_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_stall,
  input icorr_pkg::out_item_t res_data
);

  // Hold a stalled result transaction
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // Advance a run one column per clock on the same row after each accepted result
  a_run_next: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !res_data.last_of_run |=>
      res_valid && res_data.out_x == $past(res_data.out_x) + 10'd1 &&
      res_data.out_y == $past(res_data.out_y))
    else $error("run of results broken");

  // Frame end closes its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.end_of_frame |-> res_data.last_of_run)
    else $error("frame end not last of run");

endmodule

bind image_correlation_2d icorr_check u_check (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

@@ tb/tb_image_correlation_2d.sv @@
// ----------------------------------------------------------------------------
// tb_image_correlation_2d
// Self-checking bench for the streaming 3x3 image correlation block. Frames
// of random size and content go through the pixel channel with random idle
// bursts on both sides. A cycle-free predictor that tracks line memory,
// window and raster position works out every result at the moment a pixel
// transaction is accepted, and a monitor compares each result transaction
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_image_correlation_2d;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 290;
  localparam int SETTLE_CYCLES  = 32;    // covers pipeline depth plus a full stall burst
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int LINE_LEN       = 1024;  // MAX_WIDTH of the instance

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  icorr_pkg::in_item_t  pix_data = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  icorr_pkg::out_item_t res_data;
  logic                 cfg_write = 1'b0;
  logic [icorr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [icorr_pkg::CFG_W-1:0]     cfg_data = '0;

  // Shadow copy of the block: registers, line memory, window, raster position
  logic [icorr_pkg::WREG_W-1:0] img_w_reg;
  logic [icorr_pkg::HREG_W-1:0] img_h_reg;
  logic [icorr_pkg::CFG_W-1:0]  kern [icorr_pkg::KROWS_MAX];
  logic [icorr_pkg::COEF_W-1:0] line_mem [icorr_pkg::KROWS_MAX-1][LINE_LEN];
  logic [icorr_pkg::COEF_W-1:0] win [icorr_pkg::KROWS_MAX][icorr_pkg::KCOLS_MAX];
  int unsigned                  col_pos;
  int unsigned                  row_pos;

  icorr_pkg::in_item_t  pending_pixels [$];  // filled by the stimulus, drained by the driver
  icorr_pkg::out_item_t expected_sums [$];   // predicted results, oldest first
  icorr_pkg::out_item_t want;

  int pixels_sent  = 0;
  int pixels_taken = 0;
  int rand_items   = 0;
  int mismatches   = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int idle_cycles  = 0;

  image_correlation_2d dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Width and height as the block applies them: zero acts as one, oversize clamps.
  function automatic int unsigned eff_width(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > LINE_LEN) return LINE_LEN;
    return raw;
  endfunction

  function automatic int unsigned eff_height(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > int'(icorr_pkg::HEIGHT_LIMIT)) return int'(icorr_pkg::HEIGHT_LIMIT);
    return raw;
  endfunction

  // Sum for output column x while the newest window column sits at column c.
  // Window columns that fall outside the kernel footprint are skipped, which
  // also gives the zero padding at the right edge.
  function automatic logic signed [icorr_pkg::SUM_W-1:0] window_sum(int unsigned c,
                                                                     int unsigned x);
    logic signed [icorr_pkg::SUM_W-1:0] acc;
    int j;
    acc = '0;
    for (int m = 0; m < icorr_pkg::KROWS_MAX; m++) begin
      for (int n = 0; n < icorr_pkg::KCOLS_MAX; n++) begin
        j = int'(x) + n + (icorr_pkg::KCOLS_MAX - 1) - int'(c);
        if (j < 0 || j > icorr_pkg::KCOLS_MAX - 1) continue;
        acc = acc + $signed(win[m][j]) *
                    $signed(kern[m][icorr_pkg::COEF_W*n +: icorr_pkg::COEF_W]);
      end
    end
    return acc;
  endfunction

  // Advance the shadow block by one accepted pixel transaction and queue the
  // results it causes.
  function automatic void predict_correlation(icorr_pkg::in_item_t it);
    int unsigned w, h, total, c, r, y, xlo, xhi;
    logic [icorr_pkg::COEF_W-1:0] v;
    logic last_col, last_row;
    icorr_pkg::out_item_t o;
    w = eff_width(32'(img_w_reg));
    h = eff_height(32'(img_h_reg));
    total = h + icorr_pkg::KROWS_MAX - 1;
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = row_pos;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= total);

    // Only a pixel command inside an image row carries data; all else is zero.
    v = (it.command == icorr_pkg::CMD_PIXEL && r < h) ? it.pixel_value : '0;

    for (int m = 0; m < icorr_pkg::KROWS_MAX; m++) begin
      win[m][0] = win[m][1];
      win[m][1] = win[m][2];
      win[m][2] = (m < icorr_pkg::KROWS_MAX - 1) ? line_mem[m][c] : v;
    end
    line_mem[0][c] = line_mem[1][c];
    line_mem[1][c] = v;

    if (r >= icorr_pkg::KROWS_MAX - 1 && r - (icorr_pkg::KROWS_MAX - 1) < h &&
        (last_col || c >= icorr_pkg::KCOLS_MAX - 1)) begin
      y = r - (icorr_pkg::KROWS_MAX - 1);
      if (last_col) begin
        // The last column also flushes the right-edge results.
        xlo = (c >= icorr_pkg::KCOLS_MAX - 1) ? c - (icorr_pkg::KCOLS_MAX - 1) : 0;
        xhi = c;
      end else begin
        xlo = c - (icorr_pkg::KCOLS_MAX - 1);
        xhi = xlo;
      end
      for (int unsigned x = xlo; x <= xhi; x++) begin
        o.result_value = window_sum(c, x);
        o.out_x        = x[icorr_pkg::X_W-1:0];
        o.out_y        = y[icorr_pkg::Y_W-1:0];
        o.last_of_run  = (x == xhi);
        o.end_of_frame = (y + 1 == h && x + 1 == w);
        expected_sums = {expected_sums, o};
      end
    end

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = (r >= total) ? total - 1 : r;
    end
  endfunction

  // Pixel transactions left until the shadow position wraps to a new frame.
  function automatic int unsigned items_to_frame_end();
    int unsigned w, h, c, n;
    w = eff_width(32'(img_w_reg));
    h = eff_height(32'(img_h_reg));
    c = (col_pos >= w) ? w - 1 : col_pos;
    n = w - c;
    if (row_pos + 1 < h + icorr_pkg::KROWS_MAX - 1)
      n += (h + icorr_pkg::KROWS_MAX - 2 - row_pos) * w;
    return n;
  endfunction

  function automatic logic [icorr_pkg::CFG_W-1:0] rand_word();
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    return rnd[icorr_pkg::CFG_W-1:0];
  endfunction

  function automatic logic [icorr_pkg::COEF_W-1:0] rand_coef();
    int          offset;
    logic [31:0] rnd;
    offset = int'($urandom_range(0, 8)) - 4;
    rnd = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return offset[icorr_pkg::COEF_W-1:0];
      default: return rnd[icorr_pkg::COEF_W-1:0];
    endcase
  endfunction

  function automatic logic [icorr_pkg::CFG_W-1:0] rand_kernel_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [icorr_pkg::COEF_W-1:0] rand_pixel();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return rnd[icorr_pkg::COEF_W-1:0];
    endcase
  endfunction

  function automatic void queue_item(logic cmd, logic [icorr_pkg::COEF_W-1:0] val);
    icorr_pkg::in_item_t it;
    it.command     = cmd;
    it.pixel_value = val;
    pending_pixels = {pending_pixels, it};
    pixels_sent++;
  endfunction

  // One whole frame in raster order: image rows of pixels, then the drain
  // rows. A share of the commands is flipped to hit the mismatch handling.
  function automatic void queue_frame(int unsigned w, int unsigned h, int bad_pct);
    logic cmd;
    for (int unsigned r = 0; r < h + icorr_pkg::KROWS_MAX - 1; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        cmd = (r < h) ? icorr_pkg::CMD_PIXEL : icorr_pkg::CMD_DRAIN;
        if ($urandom_range(0, 99) < bad_pct)
          cmd = (cmd == icorr_pkg::CMD_PIXEL) ? icorr_pkg::CMD_DRAIN : icorr_pkg::CMD_PIXEL;
        queue_item(cmd, rand_pixel());
      end
    end
  endfunction

  function automatic void queue_loose(int unsigned n);
    repeat (n)
      queue_item($urandom_range(0, 1) ? icorr_pkg::CMD_DRAIN : icorr_pkg::CMD_PIXEL,
                 rand_pixel());
  endfunction

  // Register write; the shadow copy takes the value at once since the block
  // is idle whenever this runs.
  task automatic write_reg(logic [icorr_pkg::CFG_IDX_W-1:0] idx,
                           logic [icorr_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      icorr_pkg::REG_WIDTH:  img_w_reg = data[icorr_pkg::WREG_W-1:0];
      icorr_pkg::REG_HEIGHT: img_h_reg = data[icorr_pkg::HREG_W-1:0];
      icorr_pkg::REG_KROW0, icorr_pkg::REG_KROW1, icorr_pkg::REG_KROW2:
        kern[idx - icorr_pkg::REG_KROW0] = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Write width and height with junk above the register bits.
  task automatic set_frame(logic [icorr_pkg::WREG_W-1:0] w_raw,
                           logic [icorr_pkg::HREG_W-1:0] h_raw);
    logic [icorr_pkg::CFG_W-1:0] junk;
    junk = rand_word();
    write_reg(icorr_pkg::REG_WIDTH, {junk[icorr_pkg::CFG_W-1:icorr_pkg::WREG_W], w_raw});
    junk = rand_word();
    write_reg(icorr_pkg::REG_HEIGHT, {junk[icorr_pkg::CFG_W-1:icorr_pkg::HREG_W], h_raw});
  endtask

  task automatic set_kernel();
    write_reg(icorr_pkg::REG_KROW0, rand_kernel_row());
    write_reg(icorr_pkg::REG_KROW1, rand_kernel_row());
    write_reg(icorr_pkg::REG_KROW2, rand_kernel_row());
  endtask

  // Wait until every queued pixel is taken and every result has come back,
  // then let the pipeline empty out items that carry no result.
  task automatic wait_drained();
    @(posedge clk);
    while (pixels_taken != pixels_sent || expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel driver: predict on each accepted transaction, then either insert an
  // idle burst or present the next pending pixel. A presented pixel holds
  // until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (pix_valid && !pix_stall) begin
        predict_correlation(pix_data);
        pixels_taken++;
      end
      if (!pix_valid || !pix_stall) begin
        if (gap_left == 0 && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 15);
        if (gap_left > 0) begin
          gap_left--;
          pix_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          pix_valid <= 1'b1;
          pix_data  <= pending_pixels.pop_front();
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result transaction against the oldest
  // prediction, and throw random stall bursts at the block.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: value %0d x %0d y %0d last %0b eof %0b",
                     res_data.result_value, res_data.out_x, res_data.out_y,
                     res_data.last_of_run, res_data.end_of_frame);
        end else begin
          want = expected_sums.pop_front();
          if (res_data.result_value !== want.result_value || res_data.out_x !== want.out_x ||
              res_data.out_y !== want.out_y || res_data.last_of_run !== want.last_of_run ||
              res_data.end_of_frame !== want.end_of_frame) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"result mismatch: expected value %0d x %0d y %0d last %0b eof %0b, ",
                        "got value %0d x %0d y %0d last %0b eof %0b"},
                       want.result_value, want.out_x, want.out_y, want.last_of_run,
                       want.end_of_frame, res_data.result_value, res_data.out_x,
                       res_data.out_y, res_data.last_of_run, res_data.end_of_frame);
          end
        end
      end
      if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_image_correlation_2d: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned w, h, n, frames, pick;
    logic [icorr_pkg::WREG_W-1:0] w_raw;
    logic [icorr_pkg::HREG_W-1:0] h_raw;

    // Shadow reset state
    img_w_reg = icorr_pkg::WIDTH_RESET;
    img_h_reg = icorr_pkg::HEIGHT_RESET;
    col_pos = 0;
    row_pos = 0;
    for (int m = 0; m < icorr_pkg::KROWS_MAX; m++) begin
      kern[m] = '0;
      for (int j = 0; j < icorr_pkg::KCOLS_MAX; j++) win[m][j] = '0;
    end
    for (int m = 0; m < icorr_pkg::KROWS_MAX - 1; m++)
      for (int c = 0; c < LINE_LEN; c++) line_mem[m][c] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: 3x3 frame with extreme coefficients and pixels so that nine
    // full-scale products wrap the sum; a drain command inside an image row
    // and a pixel command inside a drain row both act as zero samples.
    write_reg(icorr_pkg::REG_KROW0, {16'h8000, 16'h8000, 16'h8000});
    write_reg(icorr_pkg::REG_KROW1, {16'h8000, 16'h7FFF, 16'h8000});
    write_reg(icorr_pkg::REG_KROW2, {16'hFFFF, 16'h8000, 16'h8000});
    set_frame(11'd3, 13'd3);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h8000);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h8000);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h8000);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h8000);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h7FFF);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h8000);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h8000);
    queue_item(icorr_pkg::CMD_DRAIN, 16'h5A5A);
    queue_item(icorr_pkg::CMD_PIXEL, 16'hFFFF);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h7FFF);
    queue_item(icorr_pkg::CMD_DRAIN, 16'h0000);
    queue_item(icorr_pkg::CMD_DRAIN, 16'hFFFF);
    queue_item(icorr_pkg::CMD_DRAIN, 16'h8000);
    queue_item(icorr_pkg::CMD_DRAIN, 16'h7FFF);
    queue_item(icorr_pkg::CMD_DRAIN, 16'h0000);
    wait_drained();

    // Unused register indexes must leave everything alone; zero width and
    // zero height act as a 1x1 image.
    write_reg(icorr_pkg::REG_KROW2 + 3'd1, rand_word());
    write_reg('1, rand_word());
    set_frame('0, '0);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h7FFF);
    queue_item(icorr_pkg::CMD_DRAIN, 16'h0000);
    queue_item(icorr_pkg::CMD_PIXEL, 16'h8000);
    wait_drained();

    // Random frames, mostly small. Some frames are cut short, resized and
    // given a new kernel row in the middle, then run to their end.
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      case ($urandom_range(0, 9))
        0: pick = 0;
        1: pick = $urandom_range(13, 40);
        default: pick = $urandom_range(1, 12);
      endcase
      w_raw = pick[icorr_pkg::WREG_W-1:0];
      case ($urandom_range(0, 9))
        0: pick = 0;
        1: pick = $urandom_range(7, 12);
        default: pick = $urandom_range(1, 6);
      endcase
      h_raw = pick[icorr_pkg::HREG_W-1:0];
      if ($urandom_range(0, 4) != 0) set_frame(w_raw, h_raw);
      if ($urandom_range(0, 2) != 0) write_reg(icorr_pkg::REG_KROW0, rand_kernel_row());
      if ($urandom_range(0, 2) != 0) write_reg(icorr_pkg::REG_KROW1, rand_kernel_row());
      if ($urandom_range(0, 2) != 0) write_reg(icorr_pkg::REG_KROW2, rand_kernel_row());
      w = eff_width(32'(img_w_reg));
      h = eff_height(32'(img_h_reg));

      if ($urandom_range(0, 5) == 0) begin
        // Stop mid-frame, pick a width up to the current one and a height up to eight, then finish.
        n = $urandom_range(1, w * (h + icorr_pkg::KROWS_MAX - 1) - 1);
        queue_loose(n);
        rand_items += n;
        wait_drained();
        pick = $urandom_range(0, w);
        w_raw = pick[icorr_pkg::WREG_W-1:0];
        pick = $urandom_range(0, 8);
        h_raw = pick[icorr_pkg::HREG_W-1:0];
        set_frame(w_raw, h_raw);
        write_reg(icorr_pkg::REG_KROW1, rand_kernel_row());
        n = items_to_frame_end();
        queue_loose(n);
        rand_items += n;
      end else begin
        // One or two back-to-back frames check the wrap to row 0 without a pause.
        frames = $urandom_range(1, 2);
        repeat (frames) queue_frame(w, h, 8);
        rand_items += frames * w * (h + icorr_pkg::KROWS_MAX - 1);
      end
      wait_drained();
    end

    // Oversize width and height clamp; a short stretch runs at the clamped
    // bounds, then a narrow width finishes the frame from where it stands.
    gap_pct = 10;
    stall_pct = 10;
    set_kernel();
    set_frame('1, '1);
    queue_loose(20);
    wait_drained();
    set_frame(11'd4, 13'd1);
    n = items_to_frame_end();
    queue_loose(n);
    wait_drained();

    // Final stretch at full rate with no idling on either side.
    gap_pct = 0;
    stall_pct = 0;
    set_kernel();
    set_frame(11'd9, 13'd4);
    queue_frame(9, 4, 5);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb_image_correlation_2d: PASS");
    end else begin
      $display("tb_image_correlation_2d: FAIL");
    end
    $finish;
  end

endmodule
